FILE: rtl/tets_pkg.sv
// Shared codes and types of the timed event table scheduler.
`default_nettype none
package tets_pkg;

  // Operation codes carried by the request channel.
  localparam logic [2:0] OP_SCHED_ON  = 3'd0;
  localparam logic [2:0] OP_SCHED_OFF = 3'd1;
  localparam logic [2:0] OP_REMOVE    = 3'd2;
  localparam logic [2:0] OP_RANDOMIZE = 3'd3;
  localparam logic [2:0] OP_TICK      = 3'd4;

  // Status codes of the response channel.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_EVENT = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_COMMAND  = 2'd3;

  // Day codes with a rule of their own.
  localparam logic [3:0] DAY_SUNDAY   = 4'd0;
  localparam logic [3:0] DAY_SATURDAY = 4'd6;
  localparam logic [3:0] DAY_EVERY    = 4'd7;
  localparam logic [3:0] DAY_WEEKDAY  = 4'd8;
  localparam logic [3:0] DAY_WEEKEND  = 4'd9;

  localparam int PORT_ID_W = 8;
  localparam int DAY_W     = 4;
  localparam int IN_MIN_W  = 11;
  localparam int MIN_W     = 12;
  localparam int OFF_W     = 7;

  // Compare results for the slot under the scan pointer.
  typedef struct packed {
    logic free;
    logic exact;
    logic due;
  } tets_hit_t;

endpackage
`default_nettype wire

FILE: rtl/tets_req_if.sv
// Request channel: one operation with its key fields.
`default_nettype none
interface tets_req_if;
  logic              valid;
  logic              ready;
  logic [2:0]        operation;
  logic [7:0]        light_id;
  logic [3:0]        day_code;
  logic [10:0]       minute;
  logic signed [6:0] random_offset;

  modport source (output valid, operation, light_id, day_code, minute, random_offset,
                  input ready);
  modport sink (input valid, operation, light_id, day_code, minute, random_offset,
                output ready);
endinterface
`default_nettype wire

FILE: rtl/tets_rsp_if.sv
// Response channel: status words and light commands.
`default_nettype none
interface tets_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] command_id;
  logic       turn_on;
  logic       last;

  modport source (output valid, status, command_id, turn_on, last, input ready);
  modport sink (input valid, status, command_id, turn_on, last, output ready);
endinterface
`default_nettype wire

FILE: rtl/tets_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module tets_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 64,
  parameter int ADDR_W = 6
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/tets_match.sv
// Compare unit shared by all slots: free, exact key match and due-now tests.
`default_nettype none
module tets_match #(
  parameter int ID_W = 8
) (
  input  wire logic                         slot_used,
  input  wire logic [ID_W-1:0]              slot_id,
  input  wire logic [tets_pkg::DAY_W-1:0]   slot_day,
  input  wire logic [tets_pkg::MIN_W-1:0]   slot_min,
  input  wire logic [ID_W-1:0]              key_id,
  input  wire logic [tets_pkg::DAY_W-1:0]   key_day,
  input  wire logic [tets_pkg::IN_MIN_W-1:0] key_min,
  output tets_pkg::tets_hit_t               hit
);
  import tets_pkg::*;

  logic min_eq;
  logic weekend;
  logic day_ok;

  assign min_eq  = (slot_min == {1'b0, key_min});
  assign weekend = (key_day == DAY_SUNDAY) || (key_day == DAY_SATURDAY);
  assign day_ok  = (slot_day == DAY_EVERY) || (slot_day == key_day) ||
                   ((slot_day == DAY_WEEKEND) && weekend) ||
                   ((slot_day == DAY_WEEKDAY) && !weekend);

  always_comb begin
    hit.free  = !slot_used;
    hit.exact = slot_used && (slot_id == key_id) && (slot_day == key_day) && min_eq;
    hit.due   = slot_used && day_ok && min_eq;
  end
endmodule
`default_nettype wire

FILE: rtl/timed_event_table_scheduler.sv
// Top level of the timed event table scheduler: sequencer, slot flags and output stage.
//
// Usage: operations arrive on the request channel (valid/ready). Schedule on/off
// places an event in the first free slot, remove and randomize act on the first
// slot whose id, day and minute match exactly, and a tick emits one light command
// per event that is due. Schedule, remove and randomize give exactly one response
// with last set; a tick gives zero or more commands in slot order, the final one
// marked last. Operation codes five to seven are dropped without a response.
// The sequencer walks the table one slot per cycle through the shared compare
// unit, reading the event RAM one slot ahead; only a tick that waits on the
// receiver holds it. A new request is taken only when the sequencer is idle again,
// so not before the last operation is through; a tick always walks the whole table.
// The response sits in an output register, so the next request is taken while a
// result still waits. If the receiver stalls, a tick holds its scan on the slot
// whose command cannot yet be handed over, and the final response waits in place.
// Reset (rst, synchronous) clears every slot flag and the channel state at once;
// the event RAM itself is not cleared, only flagged slots are ever used.
`default_nettype none
module timed_event_table_scheduler #(
  parameter int TABLE_ENTRIES = 64,
  parameter int ID_BITS = 8
) (
  input wire logic clk,
  input wire logic rst,
  tets_req_if.sink   request,
  tets_rsp_if.source response
);
  import tets_pkg::*;

  localparam int ID_W    = (ID_BITS < PORT_ID_W) ? ID_BITS : PORT_ID_W;
  localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int ENTRY_W = ID_W + DAY_W + MIN_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state, state_next;

  logic [TABLE_ENTRIES-1:0] slot_valid;
  logic [IDX_W-1:0] idx, idx_next;

  logic [2:0]             key_op;
  logic [ID_W-1:0]        key_id;
  logic [DAY_W-1:0]       key_day;
  logic [IN_MIN_W-1:0]    key_min;
  logic signed [OFF_W-1:0] key_off;

  logic [1:0]      hold_status, hold_status_next;
  logic [ID_W-1:0] hold_id, hold_id_next;
  logic            hold_on, hold_on_next;
  logic            hold_valid, hold_valid_next;

  logic       out_valid;
  logic [1:0] out_status;
  logic [7:0] out_id;
  logic       out_on;
  logic       out_last;
  logic       load_out;
  logic       load_last;
  logic       out_free;
  logic       accept;
  logic       valid_set, valid_clr;

  logic               ram_we;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] rdata;

  logic [ID_W-1:0]  e_id;
  logic [DAY_W-1:0] e_day;
  logic [MIN_W-1:0] e_min;
  logic             e_on;
  logic [MIN_W-1:0] new_min;
  tets_hit_t        hit;
  logic             at_end;

  assign {e_id, e_day, e_min, e_on} = rdata;
  assign new_min  = e_min + MIN_W'(key_off);
  assign at_end   = (idx == LAST_IDX);
  assign out_free = !out_valid || response.ready;
  assign accept   = request.valid && request.ready;

  assign request.ready       = (state == S_IDLE);
  assign response.valid      = out_valid;
  assign response.status     = out_status;
  assign response.command_id = out_id;
  assign response.turn_on    = out_on;
  assign response.last       = out_last;

  // The read address runs one slot ahead so that rdata belongs to idx.
  tets_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_ENTRIES),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(idx),
    .wdata(ram_wdata),
    .raddr(idx_next),
    .rdata(rdata)
  );

  tets_match #(
    .ID_W(ID_W)
  ) u_match (
    .slot_used(slot_valid[idx]),
    .slot_id  (e_id),
    .slot_day (e_day),
    .slot_min (e_min),
    .key_id   (key_id),
    .key_day  (key_day),
    .key_min  (key_min),
    .hit      (hit)
  );

  always_comb begin
    state_next       = state;
    idx_next         = idx;
    hold_status_next = hold_status;
    hold_id_next     = hold_id;
    hold_on_next     = hold_on;
    hold_valid_next  = hold_valid;
    load_out         = 1'b0;
    load_last        = 1'b0;
    ram_we           = 1'b0;
    ram_wdata        = {e_id, e_day, new_min, e_on};
    valid_set        = 1'b0;
    valid_clr        = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          idx_next        = '0;
          hold_valid_next = 1'b0;
          if (request.operation <= OP_TICK) begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        unique case (key_op) inside
          OP_SCHED_ON, OP_SCHED_OFF: begin
            if (hit.free) begin
              ram_we           = 1'b1;
              ram_wdata        = {key_id, key_day, {1'b0, key_min}, key_op == OP_SCHED_ON};
              valid_set        = 1'b1;
              hold_status_next = ST_OK;
              state_next       = S_FINISH;
            end else if (at_end) begin
              hold_status_next = ST_FULL;
              state_next       = S_FINISH;
            end else begin
              idx_next = idx + 1'b1;
            end
            hold_id_next = '0;
            hold_on_next = 1'b0;
          end
          OP_REMOVE, OP_RANDOMIZE: begin
            if (hit.exact) begin
              if (key_op == OP_REMOVE) begin
                valid_clr = 1'b1;
              end else begin
                ram_we = 1'b1;
              end
              hold_status_next = ST_OK;
              state_next       = S_FINISH;
            end else if (at_end) begin
              hold_status_next = ST_NO_EVENT;
              state_next       = S_FINISH;
            end else begin
              idx_next = idx + 1'b1;
            end
            hold_id_next = '0;
            hold_on_next = 1'b0;
          end
          OP_TICK: begin
            // A due event displaces the held command, which then goes out
            // without last; hold the scan on such an event while the output stage is busy.
            if (!(hit.due && hold_valid && !out_free)) begin
              if (hit.due) begin
                load_out         = hold_valid;
                hold_status_next = ST_COMMAND;
                hold_id_next     = e_id;
                hold_on_next     = e_on;
                hold_valid_next  = 1'b1;
              end
              if (at_end) begin
                state_next = hold_valid_next ? S_FINISH : S_IDLE;
              end else begin
                idx_next = idx + 1'b1;
              end
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_FINISH: begin
        if (out_free) begin
          load_out   = 1'b1;
          load_last  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_valid <= '0;
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
      idx        <= '0;
    end else begin
      state      <= state_next;
      idx        <= idx_next;
      hold_valid <= hold_valid_next;
      if (valid_set) begin
        slot_valid[idx] <= 1'b1;
      end else if (valid_clr) begin
        slot_valid[idx] <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (response.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (accept) begin
      key_op  <= request.operation;
      key_id  <= request.light_id[ID_W-1:0];
      key_day <= request.day_code;
      key_min <= request.minute;
      key_off <= request.random_offset;
    end
    hold_status <= hold_status_next;
    hold_id     <= hold_id_next;
    hold_on     <= hold_on_next;
    if (load_out) begin
      out_status <= hold_status;
      out_id     <= PORT_ID_W'(hold_id);
      out_on     <= hold_on;
      out_last   <= load_last;
    end
  end
endmodule
`default_nettype wire

FILE: tb/sv/tets_checker.sv
// Checker for the timed event table scheduler: predicts each transfer and compares responses.
`timescale 1ns / 100ps
module tets_checker #(
  parameter int TABLE_ENTRIES = 64,
  parameter int ID_BITS = 8
) (
  input  logic clk,
  input  logic rst,
  tets_req_if  request,
  tets_rsp_if  response,
  output int   failures,
  output int   outstanding
);
  import tets_pkg::*;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] command_id;
    logic       turn_on;
    logic       last;
  } light_result_t;

  localparam logic [7:0] ID_MASK = 8'((1 << ID_BITS) - 1);

  logic             slot_used   [TABLE_ENTRIES];
  logic [7:0]       slot_light  [TABLE_ENTRIES];
  logic [DAY_W-1:0] slot_day    [TABLE_ENTRIES];
  logic [MIN_W-1:0] slot_minute [TABLE_ENTRIES];
  logic             slot_on     [TABLE_ENTRIES];

  light_result_t expected_responses[$];

  function automatic bit day_is_due(logic [DAY_W-1:0] stored, logic [DAY_W-1:0] today);
    logic weekend;
    weekend = (today == DAY_SUNDAY) || (today == DAY_SATURDAY);
    return (stored == DAY_EVERY) || (stored == today) ||
           (stored == DAY_WEEKEND && weekend) || (stored == DAY_WEEKDAY && !weekend);
  endfunction

  function automatic light_result_t status_word(logic [1:0] code);
    return '{status: code, command_id: 8'd0, turn_on: 1'b0, last: 1'b1};
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    failures++;
  endtask

  // Works out the responses of the request taken at this edge and updates the table copy.
  task automatic predict_transfer();
    int slot;
    int hit;
    logic [7:0] light;
    logic [MIN_W-1:0] key_minute;
    light_result_t commands[$];
    light = request.light_id & ID_MASK;
    key_minute = {1'b0, request.minute};
    hit = -1;
    case (request.operation)
      OP_SCHED_ON, OP_SCHED_OFF: begin
        for (slot = 0; slot < TABLE_ENTRIES; slot++)
          if (hit < 0 && !slot_used[slot]) hit = slot;
        if (hit >= 0) begin
          slot_used[hit] = 1'b1;
          slot_light[hit] = light;
          slot_day[hit] = request.day_code;
          slot_minute[hit] = key_minute;
          slot_on[hit] = (request.operation == OP_SCHED_ON);
          expected_responses.push_back(status_word(ST_OK));
        end else begin
          expected_responses.push_back(status_word(ST_FULL));
        end
      end
      OP_REMOVE, OP_RANDOMIZE: begin
        for (slot = 0; slot < TABLE_ENTRIES; slot++)
          if (hit < 0 && slot_used[slot] && slot_light[slot] == light &&
              slot_day[slot] == request.day_code && slot_minute[slot] == key_minute)
            hit = slot;
        if (hit < 0) begin
          expected_responses.push_back(status_word(ST_NO_EVENT));
        end else begin
          if (request.operation == OP_REMOVE) begin
            slot_used[hit] = 1'b0;
          end else begin
            // The stored minute wraps modulo 4096, so it may leave the day for good.
            slot_minute[hit] = slot_minute[hit] +
                {{(MIN_W - OFF_W){request.random_offset[OFF_W-1]}}, request.random_offset};
          end
          expected_responses.push_back(status_word(ST_OK));
        end
      end
      OP_TICK: begin
        for (slot = 0; slot < TABLE_ENTRIES; slot++)
          if (slot_used[slot] && day_is_due(slot_day[slot], request.day_code) &&
              slot_minute[slot] == key_minute)
            commands.push_back('{status: ST_COMMAND, command_id: slot_light[slot],
                                 turn_on: slot_on[slot], last: 1'b0});
        if (commands.size() > 0) commands[commands.size() - 1].last = 1'b1;
        foreach (commands[k]) expected_responses.push_back(commands[k]);
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_response();
    light_result_t want;
    if (expected_responses.size() == 0) begin
      report_mismatch("status of an unexpected response", response.status, -1);
      return;
    end
    want = expected_responses.pop_front();
    if (response.status != want.status)
      report_mismatch("status", response.status, want.status);
    if (response.command_id != want.command_id)
      report_mismatch("command_id", response.command_id, want.command_id);
    if (response.turn_on != want.turn_on)
      report_mismatch("turn_on", response.turn_on, want.turn_on);
    if (response.last != want.last)
      report_mismatch("last", response.last, want.last);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      expected_responses.delete();
    end else begin
      if (request.valid && request.ready) predict_transfer();
      if (response.valid && response.ready) check_response();
    end
    outstanding = expected_responses.size();
  end

endmodule

FILE: tb/sv/testbench.sv
// Top of the timed event table scheduler testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module testbench;
  import tets_pkg::*;

  localparam int TABLE_ENTRIES = 64;
  localparam int ID_BITS = 8;
  localparam int RANDOM_ITEMS = 128;
  localparam int FILL_ITEMS = 100;
  localparam int QUIET_LIMIT = 4000;
  localparam logic [10:0] MINUTE_LAST = 11'd1439;
  localparam logic [10:0] MINUTE_NOON = 11'd720;

  typedef struct {
    logic [7:0]  light;
    logic [3:0]  day;
    logic [10:0] minute;
  } event_key_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int failures;
  int outstanding;
  int burst_left;
  int quiet_cycles;
  event_key_t booked[$];

  tets_req_if request();
  tets_rsp_if response();

  timed_event_table_scheduler #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .ID_BITS(ID_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .request(request),
    .response(response)
  );

  tets_checker #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .ID_BITS(ID_BITS)
  ) response_check (
    .clk(clk),
    .rst(rst),
    .request(request),
    .response(response),
    .failures(failures),
    .outstanding(outstanding)
  );

  always #5 clk = ~clk;

  // Ends the run when no transfer happens on either channel for too long.
  always @(posedge clk) begin
    if (rst || (request.valid && request.ready) || (response.valid && response.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // The receiver switches between always ready, coin tosses and long stalls.
  initial begin
    int mode;
    int run;
    response.ready = 1'b0;
    run = 0;
    forever begin
      @(posedge clk);
      if (run == 0) begin
        mode = $urandom_range(0, 2);
        run = $urandom_range(20, 120);
      end
      run--;
      case (mode)
        0: response.ready <= 1'b1;
        1: response.ready <= 1'($urandom_range(0, 1));
        default: response.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Sends one request in bursts of random length, with a random gap before a new burst.
  task automatic issue(logic [2:0] op, logic [7:0] light, logic [3:0] day,
                       logic [10:0] minute, logic signed [6:0] offset);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        request.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    request.valid <= 1'b1;
    request.operation <= op;
    request.light_id <= light;
    request.day_code <= day;
    request.minute <= minute;
    request.random_offset <= offset;
    @(posedge clk);
    while (!request.ready) @(posedge clk);
  endtask

  // Holds the sender until every expected response has been taken.
  task automatic drain();
    request.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  function automatic logic [10:0] pick_minute();
    case ($urandom_range(0, 3))
      0: return 11'd0;
      1: return MINUTE_LAST;
      2: return MINUTE_NOON;
      default: return 11'($urandom);
    endcase
  endfunction

  // One random operation, shaped so that removes, randomizes and ticks mostly hit the table.
  task automatic random_operation(bit filling);
    int roll;
    int idx;
    bit known;
    event_key_t key;
    logic [2:0] op;
    logic signed [6:0] offset;
    logic [11:0] moved;
    roll = $urandom_range(0, 99);
    offset = 7'($urandom);
    known = (booked.size() > 0) && ($urandom_range(0, 4) != 0);
    idx = (booked.size() > 0) ? $urandom_range(0, booked.size() - 1) : 0;
    if (known) begin
      key = booked[idx];
    end else begin
      key.light = 8'($urandom);
      key.day = 4'($urandom_range(0, 9));
      key.minute = pick_minute();
    end
    if (roll < (filling ? 70 : 15)) begin
      op = $urandom_range(0, 1) ? OP_SCHED_ON : OP_SCHED_OFF;
      key.light = 8'($urandom);
      key.day = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(0, 9));
      key.minute = pick_minute();
      issue(op, key.light, key.day, key.minute, offset);
      if (booked.size() < 96) booked.push_back(key);
    end else if (roll < (filling ? 80 : 55)) begin
      issue(OP_REMOVE, key.light, key.day, key.minute, offset);
      if (known) booked.delete(idx);
    end else if (roll < (filling ? 88 : 70)) begin
      if ($urandom_range(0, 1)) offset = 7'($urandom_range(0, 2)) - 7'sd1;
      issue(OP_RANDOMIZE, key.light, key.day, key.minute, offset);
      if (known) begin
        moved = {1'b0, key.minute} + {{5{offset[6]}}, offset};
        if (moved[11]) booked.delete(idx);
        else booked[idx].minute = moved[10:0];
      end
    end else begin
      key.day = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 6));
      if (!known || $urandom_range(0, 2) == 0) key.minute = pick_minute();
      issue(OP_TICK, 8'($urandom), key.day, key.minute, offset);
    end
  endtask

  initial begin
    int count;
    request.valid = 1'b0;
    request.operation = OP_TICK;
    request.light_id = 8'd0;
    request.day_code = DAY_SUNDAY;
    request.minute = 11'd0;
    request.random_offset = 7'sd0;
    burst_left = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part: empty table, every day rule, duplicates, wrapped minutes, unknown codes.
    issue(OP_TICK, 8'd0, 4'd3, 11'd0, 7'sd0);
    issue(OP_REMOVE, 8'd1, 4'd1, 11'd1, 7'sd0);
    issue(OP_SCHED_ON, 8'd0, DAY_EVERY, 11'd0, 7'sd0);
    issue(OP_SCHED_OFF, 8'hFF, DAY_WEEKDAY, MINUTE_LAST, 7'sd0);
    issue(OP_SCHED_ON, 8'h5A, DAY_WEEKEND, MINUTE_LAST, 7'sd0);
    issue(OP_SCHED_OFF, 8'h3C, 4'd3, MINUTE_LAST, 7'sd0);
    issue(OP_SCHED_ON, 8'hA5, 4'd15, 11'd0, 7'sd0);
    issue(OP_SCHED_ON, 8'h3C, 4'd3, MINUTE_LAST, 7'sd0);
    issue(OP_TICK, 8'd0, 4'd3, MINUTE_LAST, 7'sd0);
    issue(OP_TICK, 8'd0, DAY_SUNDAY, MINUTE_LAST, 7'sd0);
    issue(OP_TICK, 8'd0, DAY_SATURDAY, MINUTE_LAST, 7'sd0);
    issue(OP_TICK, 8'd0, 4'd15, 11'd0, 7'sd0);
    issue(OP_TICK, 8'd0, 4'd12, MINUTE_LAST, 7'sd0);
    issue(OP_REMOVE, 8'h3C, 4'd3, MINUTE_LAST, 7'sd0);
    issue(OP_TICK, 8'd0, 4'd3, MINUTE_LAST, 7'sd0);
    issue(OP_RANDOMIZE, 8'd0, DAY_EVERY, 11'd0, -7'sd1);
    issue(OP_TICK, 8'd0, 4'd2, 11'h7FF, 7'sd0);
    issue(OP_RANDOMIZE, 8'd0, DAY_EVERY, 11'd0, 7'sd5);
    issue(OP_RANDOMIZE, 8'h5A, DAY_WEEKEND, MINUTE_LAST, 7'sd63);
    issue(OP_TICK, 8'd0, DAY_SUNDAY, 11'd1502, 7'sd0);
    issue(OP_RANDOMIZE, 8'h5A, DAY_WEEKEND, 11'd1502, 7'h40);
    issue(OP_TICK + 3'd1, 8'h5A, DAY_WEEKEND, MINUTE_LAST, 7'sd0);
    issue(OP_TICK + 3'd3, 8'hFF, 4'hF, 11'h7FF, 7'h7F);
    issue(OP_SCHED_OFF, 8'h81, 4'd10, 11'h7FF, 7'sd0);
    issue(OP_REMOVE, 8'hA5, 4'd15, 11'd0, 7'sd0);
    drain();

    // Random part: the table fills up first, then removes dominate.
    count = 0;
    while (count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) == 0) begin
        issue(OP_TICK + 3'($urandom_range(1, 3)), 8'($urandom), 4'($urandom),
              11'($urandom), 7'($urandom));
      end else begin
        random_operation(count < FILL_ITEMS);
        count++;
      end
      if ($urandom_range(0, 29) == 0) drain();
    end
    drain();

    repeat (TABLE_ENTRIES + 8) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/tets_pkg.sv
rtl/tets_req_if.sv
rtl/tets_rsp_if.sv
rtl/tets_ram.sv
rtl/tets_match.sv
rtl/timed_event_table_scheduler.sv
tb/sv/tets_checker.sv
tb/sv/testbench.sv
